[design/touch_soft_key_gesture_classifier_core_assert.svh]
// Assertion macros shared by the gesture classifier checker.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef TOUCH_SOFT_KEY_GESTURE_CLASSIFIER_CORE_ASSERT_SVH
`define TOUCH_SOFT_KEY_GESTURE_CLASSIFIER_CORE_ASSERT_SVH

// Same-cycle implication.
`define TSKG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tskg assertion failed");

// Next-cycle implication.
`define TSKG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tskg assertion failed");

`endif

[design/tskg_pkg.sv]
// Package for the touch soft-key gesture classifier: word types, config
// struct, register indexes and gesture codes. No dependencies.
`default_nettype none

package tskg_pkg;

  localparam int unsigned CoordW  = 12;
  localparam int unsigned CountW  = 4;
  localparam int unsigned TimeW   = 48;
  localparam int unsigned DurW    = 24;
  localparam int unsigned VolW    = 7;
  localparam int unsigned RepW    = 5;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 24;

  localparam logic [VolW-1:0] VolMax = 7'd100;

  typedef enum logic [2:0] {
    GEST_NONE  = 3'd0,
    GEST_DOWN  = 3'd1,
    GEST_UP    = 3'd2,
    GEST_LONG  = 3'd3,
    GEST_CLICK = 3'd4
  } gesture_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DOWN_KEY_X   = 3'd0,
    CFG_UP_KEY_X     = 3'd1,
    CFG_ACTION_KEY_X = 3'd2,
    CFG_KEY_ROW_Y    = 3'd3,
    CFG_LONG_PRESS   = 3'd4,
    CFG_CLICK_MIN    = 3'd5,
    CFG_VOLUME_STEP  = 3'd6,
    CFG_REPEAT_LIMIT = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [CountW-1:0] first_count;
    logic [CoordW-1:0] first_x;
    logic [CountW-1:0] second_count;
    logic [CoordW-1:0] second_x;
    logic [CoordW-1:0] second_y;
    logic [TimeW-1:0]  time_us;
    logic [VolW-1:0]   current_volume;
  } in_word_t;

  typedef struct packed {
    logic [2:0]      gesture;
    logic [VolW-1:0] new_volume;
  } out_word_t;

  typedef struct packed {
    logic [CoordW-1:0] down_key_x;
    logic [CoordW-1:0] up_key_x;
    logic [CoordW-1:0] action_key_x;
    logic [CoordW-1:0] key_row_y;
    logic [DurW-1:0]   long_press_us;
    logic [DurW-1:0]   click_min_us;
    logic [VolW-1:0]   volume_step;
    logic [RepW-1:0]   repeat_limit;
  } cfg_t;

endpackage

`default_nettype wire

[design/tskg_cfg_regs.sv]
// Configuration register file of the gesture classifier.
// Depends on tskg_pkg.
`default_nettype none

module tskg_cfg_regs
  import tskg_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               wr_en_i,
  input  wire logic [CfgIdxW-1:0] wr_index_i,
  input  wire logic [CfgDatW-1:0] wr_data_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (cfg_idx_e'(wr_index_i))
        CFG_DOWN_KEY_X:   cfg_d.down_key_x    = wr_data_i[CoordW-1:0];
        CFG_UP_KEY_X:     cfg_d.up_key_x      = wr_data_i[CoordW-1:0];
        CFG_ACTION_KEY_X: cfg_d.action_key_x  = wr_data_i[CoordW-1:0];
        CFG_KEY_ROW_Y:    cfg_d.key_row_y     = wr_data_i[CoordW-1:0];
        CFG_LONG_PRESS:   cfg_d.long_press_us = wr_data_i[DurW-1:0];
        CFG_CLICK_MIN:    cfg_d.click_min_us  = wr_data_i[DurW-1:0];
        CFG_VOLUME_STEP:  cfg_d.volume_step   = wr_data_i[VolW-1:0];
        CFG_REPEAT_LIMIT: cfg_d.repeat_limit  = wr_data_i[RepW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.down_key_x    <= 12'd60;
      cfg_q.up_key_x      <= 12'd20;
      cfg_q.action_key_x  <= 12'd40;
      cfg_q.key_row_y     <= 12'd600;
      cfg_q.long_press_us <= 24'd4000000;
      cfg_q.click_min_us  <= 24'd300000;
      cfg_q.volume_step   <= 7'd10;
      cfg_q.repeat_limit  <= 5'd10;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[design/tskg_engine.sv]
// Gesture decision logic and hold state of the classifier; state advances
// once per processed poll. Depends on tskg_pkg.
`default_nettype none

module tskg_engine
  import tskg_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_i,   // poll in word_i is consumed this cycle
  input  cfg_t      cfg_i,
  input  in_word_t  word_i,
  output out_word_t result_o
);

  logic             latched_q, latched_d;
  logic [RepW-1:0]  rep_q, rep_d;
  logic             held_q, held_d;
  logic             long_q, long_d;
  logic [TimeW-1:0] start_q, start_d;

  logic [CoordW-1:0] pt_x, pt_y;
  logic              on_row, hit_down, hit_up, hit_act, hit_rel;
  logic [VolW-1:0]   cur;
  logic [VolW:0]     vol_sum;
  logic [VolW-1:0]   vol_dn, vol_up;
  logic [TimeW-1:0]  elapsed;
  logic              ge_long, gt_click;
  logic [RepW:0]     rep_next;
  logic              rep_wrap;
  gesture_e          gest;
  logic [VolW-1:0]   vol;

  // Readings that disagree count as a release at the origin.
  always_comb begin
    if (word_i.first_count == word_i.second_count && word_i.first_x == word_i.second_x) begin
      pt_x = word_i.second_x;
      pt_y = word_i.second_y;
    end else begin
      pt_x = '0;
      pt_y = '0;
    end
  end

  assign on_row   = (pt_y == cfg_i.key_row_y);
  assign hit_down = on_row && (pt_x == cfg_i.down_key_x);
  assign hit_up   = on_row && (pt_x == cfg_i.up_key_x);
  assign hit_act  = on_row && (pt_x == cfg_i.action_key_x);
  assign hit_rel  = (pt_x == '0) && (pt_y == '0);

  assign cur     = (word_i.current_volume > VolMax) ? VolMax : word_i.current_volume;
  assign vol_dn  = (cur > cfg_i.volume_step) ? cur - cfg_i.volume_step : '0;
  assign vol_sum = {1'b0, cur} + {1'b0, cfg_i.volume_step};
  assign vol_up  = (vol_sum > {1'b0, VolMax}) ? VolMax : vol_sum[VolW-1:0];

  // Wraps modulo 2^48, giving the forward distance.
  assign elapsed  = word_i.time_us - start_q;
  assign ge_long  = (|elapsed[TimeW-1:DurW]) || (elapsed[DurW-1:0] >= cfg_i.long_press_us);
  assign gt_click = (|elapsed[TimeW-1:DurW]) || (elapsed[DurW-1:0] > cfg_i.click_min_us);

  assign rep_next = {1'b0, rep_q} + 1'b1;
  assign rep_wrap = rep_next > {1'b0, cfg_i.repeat_limit};

  always_comb begin
    latched_d = latched_q;
    rep_d     = rep_q;
    held_d    = held_q;
    long_d    = long_q;
    start_d   = start_q;
    gest      = GEST_NONE;
    vol       = cur;
    if (hit_down || hit_up) begin
      if (!latched_q) begin
        latched_d = 1'b1;
        rep_d     = '0;
        gest      = hit_down ? GEST_DOWN : GEST_UP;
        vol       = hit_down ? vol_dn : vol_up;
      end else if (rep_wrap) begin
        latched_d = 1'b0;
        rep_d     = '0;
      end else begin
        rep_d = rep_next[RepW-1:0];
      end
    end else if (hit_act) begin
      if (!held_q) begin
        held_d  = 1'b1;
        start_d = word_i.time_us;
        long_d  = 1'b0;
      end else if (!long_q && ge_long) begin
        gest   = GEST_LONG;
        long_d = 1'b1;
      end
      latched_d = 1'b1;
      rep_d     = '0;
    end else if (hit_rel) begin
      if (held_q) begin
        if (!long_q && !ge_long && gt_click) begin
          gest = GEST_CLICK;
        end
        held_d = 1'b0;
        long_d = 1'b0;
      end
      latched_d = 1'b0;
      rep_d     = '0;
    end else begin
      held_d    = 1'b0;
      long_d    = 1'b0;
      latched_d = 1'b0;
      rep_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latched_q <= 1'b0;
      rep_q     <= '0;
      held_q    <= 1'b0;
      long_q    <= 1'b0;
      start_q   <= '0;
    end else if (step_i) begin
      latched_q <= latched_d;
      rep_q     <= rep_d;
      held_q    <= held_d;
      long_q    <= long_d;
      start_q   <= start_d;
    end
  end

  assign result_o = {gest, vol};

endmodule

`default_nettype wire

[design/touch_soft_key_gesture_classifier_core.sv]
// Top level of the touch soft-key gesture classifier: input register,
// decision engine, result register. Depends on tskg_pkg, tskg_cfg_regs, tskg_engine.
//
// One word in per touch poll, one word out: a gesture code (none, volume
// down, volume up, long press, click) and the saturated volume after the
// poll. A poll is held in an input register, classified by the engine
// against the hold state, and the result lands in an output register while
// the state updates in the same cycle. Throughput is one poll per clock while
// the result side is not stalled; each poll is held in the input register
// and its result in the output register until it is taken. The input side
// stays ready while the output register can drain, so a stalled consumer
// backs up only after both registers fill. Config writes are taken in any
// cycle (cfg_ready_o is tied high) and must only happen while no poll is
// in flight; index i selects the i-th register (down_key_x, up_key_x,
// action_key_x, key_row_y, long_press_us, click_min_us, volume_step,
// repeat_limit), and the low bits of cfg_data_i are kept.
`default_nettype none

module touch_soft_key_gesture_classifier_core
  import tskg_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // poll channel
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  in_word_t                in_word_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output out_word_t               out_word_o,
  // config channel
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgDatW-1:0] cfg_data_i
);

  cfg_t      cfg;
  in_word_t  in_q;
  logic      in_valid_q;
  out_word_t out_q;
  logic      out_valid_q;
  out_word_t result;
  logic      step;

  assign cfg_ready_o = 1'b1;

  tskg_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Consume the held poll whenever the result register is free or draining.
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  tskg_engine u_engine (
    .clk_i,
    .rst_ni,
    .step_i   (step),
    .cfg_i    (cfg),
    .word_i   (in_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

[design/tskg_checker.sv]
// Port-level checker for the gesture classifier top level, bound in below.
// Depends on tskg_pkg and the assertion macro header.
`default_nettype none

`include "touch_soft_key_gesture_classifier_core_assert.svh"

module tskg_checker
  import tskg_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input in_word_t                in_word_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input out_word_t               out_word_o,
  input wire logic               cfg_valid_i,
  input wire logic               cfg_ready_o,
  input wire logic [CfgIdxW-1:0] cfg_index_i,
  input wire logic [CfgDatW-1:0] cfg_data_i
);

  // Stalled result word holds.
  `TSKG_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_word_o))
  // Input backs up only when the result side is stalled.
  `TSKG_ASSERT_IMP(a_bp_source, !in_ready_o, out_valid_o && !out_ready_i)
  `TSKG_ASSERT_IMP(a_gest_range, out_valid_o, out_word_o.gesture <= GEST_CLICK)
  `TSKG_ASSERT_IMP(a_vol_range, out_valid_o, out_word_o.new_volume <= VolMax)

endmodule

bind touch_soft_key_gesture_classifier_core tskg_checker u_tskg_checker (.*);

`default_nettype wire

[tb/touch_soft_key_gesture_classifier_core_test.sv]
// Self-checking testbench for touch_soft_key_gesture_classifier_core: directed polls,
// shared-key and extreme register settings, random gesture traffic and backpressure.
// Depends on tskg_pkg and the core RTL; expected words come from an in-line predictor.
module touch_soft_key_gesture_classifier_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tskg_pkg::*;

  // DUT hookup; every input starts at a known value
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  in_word_t           in_word_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_word_t          out_word_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  cfg_idx_e           cfg_index_i = CFG_DOWN_KEY_X;
  logic [CfgDatW-1:0] cfg_data_i  = '0;

  touch_soft_key_gesture_classifier_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copy of the register file and hold state
  cfg_t             reg_shadow;
  logic             vol_latched;
  logic [RepW-1:0]  repeat_cnt;
  logic             action_held;
  logic             long_fired;
  logic [TimeW-1:0] press_start;

  out_word_t        pending_results[$];   // predicted words, oldest first
  int               mismatches      = 0;
  int               polls_sent      = 0;
  int               send_gap_pct    = 0;  // chance per cycle that the poll side idles
  int               recv_gap_pct    = 0;  // chance per cycle that the result side stalls
  int               hold_off_cycles = 0;  // long result-side stall, counted down below
  logic [TimeW-1:0] poll_clock      = '0; // running timestamp for random polls

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Volume keys share one latch: first poll fires, held polls count until the
  // count passes repeat_limit, then the latch drops and the next poll fires again.
  function automatic logic volume_key_fires();
    logic [RepW:0] nxt;
    if (!vol_latched) begin
      vol_latched = 1'b1;
      repeat_cnt  = '0;
      return 1'b1;
    end
    nxt = repeat_cnt + 1'b1;
    if (nxt > reg_shadow.repeat_limit) begin
      vol_latched = 1'b0;
      repeat_cnt  = '0;
    end else begin
      repeat_cnt = nxt[RepW-1:0];
    end
    return 1'b0;
  endfunction

  // One poll in, one word out; updates the hold state as the block should.
  function automatic out_word_t classify_poll(in_word_t w);
    logic [CoordW-1:0] px;
    logic [CoordW-1:0] py;
    logic [VolW-1:0]   cur;
    logic [VolW:0]     raised;
    logic [TimeW-1:0]  held_us;
    out_word_t         r;
    cur          = (w.current_volume > VolMax) ? VolMax : w.current_volume;
    r.gesture    = GEST_NONE;
    r.new_volume = cur;
    // readings that disagree read as a lift at the origin
    px = '0;
    py = '0;
    if (w.first_count == w.second_count && w.first_x == w.second_x) begin
      px = w.second_x;
      py = w.second_y;
    end
    held_us = w.time_us - press_start;  // wraps mod 2^48 by width
    // key priority: down, up, action, release, anything else
    if (px == reg_shadow.down_key_x && py == reg_shadow.key_row_y) begin
      if (volume_key_fires()) begin
        r.gesture    = GEST_DOWN;
        r.new_volume = (cur > reg_shadow.volume_step) ? cur - reg_shadow.volume_step : '0;
      end
    end else if (px == reg_shadow.up_key_x && py == reg_shadow.key_row_y) begin
      if (volume_key_fires()) begin
        raised       = cur + reg_shadow.volume_step;
        r.gesture    = GEST_UP;
        r.new_volume = (raised > VolMax) ? VolMax : raised[VolW-1:0];
      end
    end else if (px == reg_shadow.action_key_x && py == reg_shadow.key_row_y) begin
      if (!action_held) begin
        action_held = 1'b1;
        press_start = w.time_us;
        long_fired  = 1'b0;
      end else if (!long_fired && held_us >= reg_shadow.long_press_us) begin
        r.gesture  = GEST_LONG;
        long_fired = 1'b1;
      end
      vol_latched = 1'b1;
      repeat_cnt  = '0;
    end else begin
      // lift: a click only for a hold strictly between the two thresholds
      if (px == '0 && py == '0 && action_held && !long_fired &&
          held_us < reg_shadow.long_press_us && held_us > reg_shadow.click_min_us) begin
        r.gesture = GEST_CLICK;
      end
      action_held = 1'b0;
      long_fired  = 1'b0;
      vol_latched = 1'b0;
      repeat_cnt  = '0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Two agreeing readings at (x, y)
  function automatic in_word_t make_poll(logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                                         logic [TimeW-1:0] stamp, logic [VolW-1:0] vol);
    in_word_t w;
    w.first_count    = CountW'($urandom_range(15));
    w.second_count   = w.first_count;
    w.first_x        = x;
    w.second_x       = x;
    w.second_y       = y;
    w.time_us        = stamp;
    w.current_volume = vol;
    return w;
  endfunction

  // Make the first reading disagree in count or in x
  function automatic in_word_t garble(in_word_t w);
    if ($urandom_range(1))
      w.first_count = w.first_count ^ CountW'($urandom_range(15, 1));
    else
      w.first_x = w.first_x ^ CoordW'($urandom_range(4095, 1));
    return w;
  endfunction

  // Mostly in range, now and then above 100 to hit the input clamp
  function automatic logic [VolW-1:0] random_volume();
    if ($urandom_range(9) == 0)
      return VolW'($urandom_range(127, 101));
    return VolW'($urandom_range(100));
  endfunction

  function automatic logic [TimeW-1:0] stamp_after(int unsigned span);
    poll_clock = poll_clock + $urandom_range(span);
    return poll_clock;
  endfunction

  // Every field random; half the time the readings agree so it lands somewhere real
  function automatic in_word_t random_poll(int unsigned span);
    in_word_t w;
    w.first_count    = CountW'($urandom);
    w.first_x        = CoordW'($urandom);
    w.second_count   = CountW'($urandom);
    w.second_x       = CoordW'($urandom);
    w.second_y       = CoordW'($urandom);
    w.current_volume = VolW'($urandom);
    if ($urandom_range(3) == 0)
      w.time_us = TimeW'({$urandom, $urandom});
    else
      w.time_us = stamp_after(span);
    if ($urandom_range(1)) begin
      w.second_count = w.first_count;
      w.second_x     = w.first_x;
    end
    return w;
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    c.key_row_y    = CoordW'($urandom);
    c.down_key_x   = CoordW'($urandom);
    c.up_key_x     = CoordW'($urandom);
    c.action_key_x = CoordW'($urandom);
    case ($urandom_range(5))
      0: c.up_key_x = c.down_key_x;       // up key hidden behind down
      1: c.action_key_x = c.up_key_x;     // action key hidden behind up
      2: begin                            // down key sits on the lift point
        c.down_key_x = '0;
        c.key_row_y  = '0;
      end
      default: ;
    endcase
    c.long_press_us = DurW'($urandom_range(3000000));
    if ($urandom_range(4) == 0)
      c.click_min_us = DurW'($urandom_range(3000000));  // may exceed long press
    else
      c.click_min_us = DurW'($urandom_range(c.long_press_us));
    c.volume_step  = VolW'($urandom_range(100));
    c.repeat_limit = RepW'($urandom);
    return c;
  endfunction

  // Offer one poll; valid stays up until accepted, prediction is made at accept
  task automatic send_poll(in_word_t w);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(classify_poll(w));
    polls_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid and wait for every predicted word to come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  // Writes all eight registers; junk above each field checks the truncation
  task automatic set_config(cfg_t c);
    cfg_idx_e           idx;
    logic [CfgDatW-1:0] wdata;
    for (int i = 0; i <= int'(CFG_REPEAT_LIMIT); i++) begin
      idx   = cfg_idx_e'(i);
      wdata = CfgDatW'($urandom);
      case (idx)
        CFG_DOWN_KEY_X:   wdata[CoordW-1:0] = c.down_key_x;
        CFG_UP_KEY_X:     wdata[CoordW-1:0] = c.up_key_x;
        CFG_ACTION_KEY_X: wdata[CoordW-1:0] = c.action_key_x;
        CFG_KEY_ROW_Y:    wdata[CoordW-1:0] = c.key_row_y;
        CFG_LONG_PRESS:   wdata[DurW-1:0]   = c.long_press_us;
        CFG_CLICK_MIN:    wdata[DurW-1:0]   = c.click_min_us;
        CFG_VOLUME_STEP:  wdata[VolW-1:0]   = c.volume_step;
        CFG_REPEAT_LIMIT: wdata[RepW-1:0]   = c.repeat_limit;
        default: ;
      endcase
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= wdata;
      do @(posedge clk_i); while (!cfg_ready_o);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    reg_shadow = c;
  endtask

  task automatic send_release(int unsigned span);
    in_word_t w;
    w = make_poll('0, '0, stamp_after(span), random_volume());
    if ($urandom_range(1))
      w = garble(w);
    send_poll(w);
  endtask

  // Mostly well-formed key sequences with random content, some noise
  task automatic run_gesture_mix(int n);
    int                stop_at;
    int                kind;
    int                reps;
    int unsigned       span;
    logic [CoordW-1:0] key_x;
    stop_at = polls_sent + n;
    // per-poll time step sized so holds land on both sides of both thresholds
    span = (reg_shadow.long_press_us >> 1) + (reg_shadow.click_min_us >> 1) + 16;
    while (polls_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        // hold a volume key long enough to see repeats, then lift
        key_x = $urandom_range(1) ? reg_shadow.down_key_x : reg_shadow.up_key_x;
        reps  = $urandom_range(reg_shadow.repeat_limit + 4, 1);
        repeat (reps)
          send_poll(make_poll(key_x, reg_shadow.key_row_y, stamp_after(span),
                              random_volume()));
        send_release(span);
      end else if (kind < 65) begin
        // action key hold; lift for click or long press, or slide off it
        reps = $urandom_range(8, 1);
        repeat (reps)
          send_poll(make_poll(reg_shadow.action_key_x, reg_shadow.key_row_y,
                              stamp_after(span), random_volume()));
        if ($urandom_range(3) == 0)
          send_poll(random_poll(span));
        else
          send_release(span);
      end else if (kind < 80) begin
        // hop between keys without lifting
        reps = $urandom_range(6, 2);
        repeat (reps) begin
          case ($urandom_range(2))
            0:       key_x = reg_shadow.down_key_x;
            1:       key_x = reg_shadow.up_key_x;
            default: key_x = reg_shadow.action_key_x;
          endcase
          send_poll(make_poll(key_x, reg_shadow.key_row_y, stamp_after(span),
                              random_volume()));
        end
      end else begin
        send_poll(random_poll(span));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset register values: clamps, volume latch, click and long-press edges
  task automatic test_directed_defaults();
    logic [TimeW-1:0] near_wrap;
    near_wrap = '1 - TimeW'(99999);
    send_poll(make_poll(60, 600, 48'd10, 7'd5));          // down, floors at 0
    send_poll(make_poll(20, 600, 48'd20, 7'd127));        // latched: nothing, clamp to 100
    send_poll(make_poll(0, 0, 48'd30, 7'd0));             // lift drops the latch
    send_poll(make_poll(20, 600, 48'd40, 7'd95));         // up, caps at 100
    send_poll(garble(make_poll(40, 600, 48'd50, 7'd64))); // disagreeing readings = lift
    // hold across the timestamp wrap, lift 350000 us later -> click
    send_poll(make_poll(40, 600, near_wrap, 7'd50));
    send_poll(make_poll(40, 600, 48'd150000, 7'd50));
    send_poll(garble(make_poll(40, 600, 48'd250000, 7'd50)));
    // hold exactly long_press_us -> long press once, no click on lift
    send_poll(make_poll(40, 600, 48'd1000, 7'd50));
    send_poll(make_poll(40, 600, 48'd4001000, 7'd50));
    send_poll(make_poll(40, 600, 48'd9000000, 7'd50));
    send_poll(make_poll(0, 0, 48'd9000100, 7'd50));
    // hold exactly click_min_us -> no click
    send_poll(make_poll(40, 600, 48'd10000000, 7'd50));
    send_poll(make_poll(0, 0, 48'd10300000, 7'd50));
    // sliding off to another point cancels the hold
    send_poll(make_poll(40, 600, 48'd11000000, 7'd50));
    send_poll(make_poll(4095, 4095, 48'd11500000, 7'd50));
    send_poll(make_poll(0, 0, 48'd11600000, 7'd50));
    // just under long press -> click
    send_poll(make_poll(40, 600, 48'd12000000, 7'd50));
    send_poll(make_poll(0, 0, 48'd15999999, 7'd50));
    // action key sets the volume latch, so down right after it stays quiet
    send_poll(make_poll(40, 600, 48'd16000000, 7'd50));
    send_poll(make_poll(60, 600, 48'd16000010, 7'd50));
    send_poll('1);                                        // every field at its top
    send_poll('0);                                        // every field at zero
  endtask

  // Coinciding keys and register extremes
  task automatic test_shared_keys();
    // all keys and the row at zero: the down key owns the lift point
    drain_results();
    set_config('{12'd0, 12'd0, 12'd0, 12'd0, 24'd0, 24'd0, 7'd0, 5'd0});
    send_poll(make_poll(0, 0, stamp_after(1000), 7'd50));
    send_poll(garble(make_poll(5, 5, stamp_after(1000), 7'd50)));
    send_poll(make_poll(0, 0, stamp_after(1000), 7'd50));
    // everything at its top: full step from 100 goes to 0
    drain_results();
    set_config('{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 24'hFFFFFF, 24'hFFFFFF, 7'd100, 5'd31});
    send_poll(make_poll(12'hFFF, 12'hFFF, stamp_after(1000), 7'd100));
    send_poll(make_poll(12'hFFF, 12'hFFF, stamp_after(1000), 7'd100));
    send_poll(make_poll(0, 0, stamp_after(1000), 7'd100));
    // action key behind the up key; full step up from 0 goes to 100
    drain_results();
    set_config('{12'd1, 12'd2, 12'd2, 12'd7, 24'd0, 24'd0, 7'd100, 5'd3});
    send_poll(make_poll(2, 7, stamp_after(1000), 7'd0));
    send_poll(make_poll(1, 7, stamp_after(1000), 7'd100));
    // zero long-press time: second poll of the hold reports at once
    drain_results();
    set_config('{12'd1, 12'd2, 12'd3, 12'd7, 24'd0, 24'd0, 7'd1, 5'd0});
    send_poll(make_poll(3, 7, stamp_after(1000), 7'd50));
    send_poll(make_poll(3, 7, poll_clock, 7'd50));
    send_poll(make_poll(0, 0, stamp_after(1000), 7'd50));
  endtask

  // Random traffic in chunks, each under a fresh register setting
  task automatic test_random_traffic(int n);
    int stop_at;
    stop_at = polls_sent + n;
    while (polls_sent < stop_at) begin
      drain_results();
      if ($urandom_range(1))
        poll_clock = TimeW'({$urandom, $urandom});
      else
        poll_clock = '1 - TimeW'($urandom_range(20000000));  // wrap inside the chunk
      set_config(random_config());
      run_gesture_mix(150);
    end
  endtask

  // Result side holds off long enough to back up the pipe and stall polls
  task automatic test_backpressure();
    drain_results();
    set_config(random_config());
    hold_off_cycles = 300;
    run_gesture_mix(60);
    drain_results();   // let everything drain before carrying on
    run_gesture_mix(40);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls plus the long hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_off_cycles--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Compare each accepted result word against the oldest prediction
  always @(posedge clk_i) begin : check_results
    out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result word with nothing pending: gesture %0d volume %0d",
                   $time, out_word_o.gesture, out_word_o.new_volume);
      end else begin
        want = pending_results.pop_front();
        if (out_word_o.gesture !== want.gesture ||
            out_word_o.new_volume !== want.new_volume) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch: gesture exp %0d got %0d, volume exp %0d got %0d",
                     $time, want.gesture, out_word_o.gesture,
                     want.new_volume, out_word_o.new_volume);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    reg_shadow  = '{12'd60, 12'd20, 12'd40, 12'd600, 24'd4000000, 24'd300000, 7'd10, 5'd10};
    vol_latched = 1'b0;
    repeat_cnt  = '0;
    action_held = 1'b0;
    long_fired  = 1'b0;
    press_start = '0;

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // poll side mostly busy, result side mostly stalled
    send_gap_pct = 7;
    recv_gap_pct = 85;
    test_directed_defaults();
    test_shared_keys();
    test_random_traffic(600);

    // the other way round
    send_gap_pct = 85;
    recv_gap_pct = 7;
    test_random_traffic(600);

    // back to back
    send_gap_pct = 0;
    recv_gap_pct = 0;
    test_random_traffic(500);
    test_backpressure();

    drain_results();
    repeat (8) @(negedge clk_i);   // catch any stray word after the last one
    if (mismatches == 0)
      $display("touch_soft_key_gesture_classifier_core_test: done, clean");
    else
      $display("touch_soft_key_gesture_classifier_core_test: done, errors");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("touch_soft_key_gesture_classifier_core_test: done, errors");
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/tskg_pkg.sv
design/tskg_cfg_regs.sv
design/tskg_engine.sv
design/touch_soft_key_gesture_classifier_core.sv
design/tskg_checker.sv
tb/touch_soft_key_gesture_classifier_core_test.sv
